@@ sv/charger_stage_controller_macros.svh @@
// ----------------------------------------------------------------------------
// Charger stage controller assertion macros
// Shorthand for clocked implication checks, sampled on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef CHARGER_STAGE_CONTROLLER_MACROS_SVH
`define CHARGER_STAGE_CONTROLLER_MACROS_SVH

// same-cycle implication
`define CSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/csc_pkg.sv @@
// ----------------------------------------------------------------------------
// csc_pkg
// Shared types and constants of the charger stage controller.
// ----------------------------------------------------------------------------
package csc_pkg;

    localparam int CFG_W     = 16;   // threshold register width
    localparam int CFG_IDX_W = 3;    // config index width
    localparam int MODE_W    = 3;    // charge mode width
    localparam int PCT_W     = 7;    // percentage width
    localparam int PCT_MAX   = 100;  // percentage clamp
    localparam int PCT_SCALE = 100;  // percentage full-scale multiplier
    localparam int PCT_SCALE_W = 7;  // bits that hold PCT_SCALE

    // register reset values
    localparam logic [CFG_W-1:0] WAKE_RST      = 16'd500;
    localparam logic [CFG_W-1:0] PRE_RST       = 16'd10500;
    localparam logic [CFG_W-1:0] PRE_HYST_RST  = 16'd200;
    localparam logic [CFG_W-1:0] FLOAT_RST     = 16'd13800;
    localparam logic [CFG_W-1:0] FLOAT_HYST_RST = 16'd200;
    localparam logic [CFG_W-1:0] COLLAPSE_RST  = 16'd300;

    // configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WAKE,
        CFG_PRE,
        CFG_PRE_HYST,
        CFG_FLOAT,
        CFG_FLOAT_HYST,
        CFG_COLLAPSE
    } cfg_idx_t;

    // charge stage, also the charge_mode code
    typedef enum logic [MODE_W-1:0] {
        ST_IDLE,
        ST_PRE,
        ST_CHG,
        ST_FLOAT,
        ST_FAULT
    } stage_t;

    // back-end sequencer
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_DONE
    } back_state_t;

    // classification carried through the queue with each sample
    typedef struct packed {
        stage_t stage;
        logic   fault;
    } csc_tag_t;

    // a - b, floored at zero
    function automatic logic [CFG_W-1:0] sub_floor0(input logic [CFG_W-1:0] a,
                                                     input logic [CFG_W-1:0] b);
        sub_floor0 = (a > b) ? (a - b) : '0;
    endfunction

endpackage

@@ sv/csc_front.sv @@
// ----------------------------------------------------------------------------
// csc_front
// Config registers, sample intake and stage classification.
// ----------------------------------------------------------------------------
module csc_front
    import csc_pkg::*;
#(
    parameter int VOLTAGE_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration
    input  logic                    cfg_valid,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    // sample intake
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    fault_active,
    input  logic [VOLTAGE_BITS-1:0] voltage_mv,
    // queue push side
    input  logic                    q_full,
    output logic                    q_push,
    output csc_tag_t                q_tag,
    output logic [VOLTAGE_BITS-1:0] q_volt,
    // full-scale value for the back end
    output logic [CFG_W-1:0]        float_mv
);

    localparam int CMP_W = (VOLTAGE_BITS > CFG_W) ? VOLTAGE_BITS : CFG_W;

    logic [CFG_W-1:0] wake_reg, pre_reg, pre_hyst_reg;
    logic [CFG_W-1:0] float_reg, float_hyst_reg, collapse_reg;
    stage_t           stage_reg, stage_next;

    logic [CMP_W-1:0] v_ext;
    logic [CMP_W-1:0] wake_ext, pre_ext, pre_lo_ext, float_ext, chg_lo_ext, flt_lo_ext;
    logic             accept;

    // configuration register file; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wake_reg       <= WAKE_RST;
            pre_reg        <= PRE_RST;
            pre_hyst_reg   <= PRE_HYST_RST;
            float_reg      <= FLOAT_RST;
            float_hyst_reg <= FLOAT_HYST_RST;
            collapse_reg   <= COLLAPSE_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_WAKE:       wake_reg       <= cfg_data;
                CFG_PRE:        pre_reg        <= cfg_data;
                CFG_PRE_HYST:   pre_hyst_reg   <= cfg_data;
                CFG_FLOAT:      float_reg      <= cfg_data;
                CFG_FLOAT_HYST: float_hyst_reg <= cfg_data;
                CFG_COLLAPSE:   collapse_reg   <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign float_mv = float_reg;

    // thresholds, widened to a common compare width
    assign v_ext      = CMP_W'(voltage_mv);
    assign wake_ext   = CMP_W'(wake_reg);
    assign pre_ext    = CMP_W'(pre_reg);
    assign pre_lo_ext = CMP_W'(sub_floor0(pre_reg, pre_hyst_reg));
    assign float_ext  = CMP_W'(float_reg);
    assign chg_lo_ext = CMP_W'(sub_floor0(float_reg, float_hyst_reg));
    assign flt_lo_ext = CMP_W'(sub_floor0(float_reg, collapse_reg));

    // stage transition for the sample at the input
    always_comb
    begin
        stage_next = stage_reg;
        if (fault_active)
        begin
            stage_next = ST_FAULT;
        end
        else
        begin
            case (stage_reg)
                ST_IDLE:
                begin
                    if (v_ext > wake_ext)
                        stage_next = ST_PRE;
                end
                ST_PRE:
                begin
                    if (v_ext > pre_ext)
                        stage_next = ST_CHG;
                    else if (v_ext < pre_lo_ext)
                        stage_next = ST_IDLE;
                end
                ST_CHG:
                begin
                    if (v_ext > float_ext)
                        stage_next = ST_FLOAT;
                    else if (v_ext < chg_lo_ext)
                        stage_next = ST_PRE;
                end
                ST_FLOAT:
                begin
                    if (v_ext < flt_lo_ext)
                        stage_next = ST_CHG;
                end
                default: stage_next = ST_FAULT;  // latched fault
            endcase
        end
    end

    // intake handshake: take a sample whenever the queue has room
    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_reg <= ST_IDLE;
        else if (accept)
            stage_reg <= stage_next;
    end

    assign q_push      = accept;
    assign q_tag.stage = stage_next;
    assign q_tag.fault = fault_active;
    assign q_volt      = voltage_mv;

endmodule

@@ sv/csc_queue.sv @@
// ----------------------------------------------------------------------------
// csc_queue
// Small first-in first-out buffer between front and back end.
// ----------------------------------------------------------------------------
module csc_queue
    import csc_pkg::*;
#(
    parameter int DATA_W = 20,
    parameter int DEPTH  = 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] wdata,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output logic [DATA_W-1:0] rdata
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign rdata     = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

@@ sv/csc_back.sv @@
// ----------------------------------------------------------------------------
// csc_back
// Percentage divider, held percentage and result register.
// ----------------------------------------------------------------------------
module csc_back
    import csc_pkg::*;
#(
    parameter int VOLTAGE_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // queue pop side
    input  logic                    q_not_empty,
    input  csc_tag_t                q_tag,
    input  logic [VOLTAGE_BITS-1:0] q_volt,
    output logic                    q_pop,
    // full-scale value
    input  logic [CFG_W-1:0]        float_mv,
    // result channel
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [MODE_W-1:0]       charge_mode,
    output logic [PCT_W-1:0]        battery_pct
);

    // numerator voltage*100 needs 7 extra bits
    localparam int NUM_W = VOLTAGE_BITS + PCT_SCALE_W;
    localparam int CNT_W = $clog2(NUM_W);

    back_state_t       state_reg, state_next;
    stage_t            mode_reg, mode_next;
    logic              fault_reg, fault_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [NUM_W-1:0]  quo_reg, quo_next;
    logic [CFG_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [PCT_W-1:0]  pct_held_reg, pct_held_next;
    logic              out_valid_reg, out_valid_next;
    logic [MODE_W-1:0] mode_out_reg, mode_out_next;
    logic [PCT_W-1:0]  pct_out_reg, pct_out_next;

    logic [CFG_W:0]    trial;
    logic              trial_ge;
    logic [PCT_W-1:0]  pct_calc;
    logic              out_free;

    // one restoring-division step
    assign trial    = {rem_reg, num_reg[NUM_W-1]};
    assign trial_ge = (trial >= {1'b0, float_mv});

    // clamp the quotient; a zero divisor gives all ones and clamps too
    assign pct_calc = (quo_reg > NUM_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : quo_reg[PCT_W-1:0];

    assign out_free = !out_valid_reg || out_ready;

    // sequencer and datapath next values
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        fault_next     = fault_reg;
        num_next       = num_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        pct_held_next  = pct_held_reg;
        out_valid_next = out_valid_reg;
        mode_out_next  = mode_out_reg;
        pct_out_next   = pct_out_reg;
        q_pop          = 1'b0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                if (q_not_empty)
                begin
                    q_pop      = 1'b1;
                    mode_next  = q_tag.stage;
                    fault_next = q_tag.fault;
                    num_next   = NUM_W'(q_volt) * NUM_W'(PCT_SCALE);
                    quo_next   = '0;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = q_tag.fault ? BK_DONE : BK_DIV;
                end
            end
            BK_DIV:
            begin
                num_next = {num_reg[NUM_W-2:0], 1'b0};
                quo_next = {quo_reg[NUM_W-2:0], trial_ge};
                rem_next = trial_ge ? CFG_W'(trial - {1'b0, float_mv}) : trial[CFG_W-1:0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1))
                    state_next = BK_DONE;
            end
            BK_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    mode_out_next  = mode_reg;
                    if (fault_reg)
                    begin
                        pct_out_next = pct_held_reg;
                    end
                    else
                    begin
                        pct_out_next  = pct_calc;
                        pct_held_next = pct_calc;
                    end
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            pct_held_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pct_held_reg  <= pct_held_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        fault_reg    <= fault_next;
        num_reg      <= num_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        cnt_reg      <= cnt_next;
        mode_out_reg <= mode_out_next;
        pct_out_reg  <= pct_out_next;
    end

    assign out_valid   = out_valid_reg;
    assign charge_mode = mode_out_reg;
    assign battery_pct = pct_out_reg;

endmodule

@@ sv/charger_stage_controller.sv @@
// A battery voltage sample (voltage_mv, low VOLTAGE_BITS bits) and a fault flag go in; one
// transaction comes out per sample with the charge mode (0 idle, 1 precharge, 2 charging,
// 3 float, 4 fault, latched until reset) and floor(voltage*100/float_mv) clamped to 100,
// held at its last value for samples that carry the fault flag. The front end updates the
// stage as it takes a sample and parks it in a two-entry queue, so samples are taken while
// the back end is busy. The back end runs a bit-serial restoring divider: a sample without
// fault is loaded, divided one quotient bit per cycle and its result registered when the
// output is free; a fault sample skips the division. Sustained throughput is set by the
// divider. Thresholds are written on the cfg port (index 0 wake, 1 precharge, 2 precharge
// hysteresis, 3 float, 4 float hysteresis, 5 collapse) by the user, only while the block
// is idle (not enforced by the block); cfg_ready is always high, unknown indexes ignored.
// ----------------------------------------------------------------------------
// charger_stage_controller
// Battery charger stage controller with percentage estimate.
// ----------------------------------------------------------------------------
module charger_stage_controller
    import csc_pkg::*;
#(
    parameter int VOLTAGE_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    // samples
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    fault_active,
    input  logic [VOLTAGE_BITS-1:0] voltage_mv,
    // results
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [MODE_W-1:0]       charge_mode,
    output logic [PCT_W-1:0]        battery_pct
);

    localparam int TAG_W = $bits(csc_tag_t);
    localparam int Q_W   = TAG_W + VOLTAGE_BITS;

    logic                    q_full, q_push, q_pop, q_not_empty;
    csc_tag_t                push_tag, pop_tag;
    logic [VOLTAGE_BITS-1:0] push_volt, pop_volt;
    logic [Q_W-1:0]          q_rdata;
    logic [CFG_W-1:0]        float_mv;

    assign cfg_ready = 1'b1;

    csc_front #(
        .VOLTAGE_BITS (VOLTAGE_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .fault_active (fault_active),
        .voltage_mv   (voltage_mv),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_tag        (push_tag),
        .q_volt       (push_volt),
        .float_mv     (float_mv)
    );

    csc_queue #(
        .DATA_W (Q_W),
        .DEPTH  (2)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .wdata     ({push_tag, push_volt}),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .rdata     (q_rdata)
    );

    assign pop_tag  = csc_tag_t'(q_rdata[Q_W-1:VOLTAGE_BITS]);
    assign pop_volt = q_rdata[VOLTAGE_BITS-1:0];

    csc_back #(
        .VOLTAGE_BITS (VOLTAGE_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_tag       (pop_tag),
        .q_volt      (pop_volt),
        .q_pop       (q_pop),
        .float_mv    (float_mv),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .charge_mode (charge_mode),
        .battery_pct (battery_pct)
    );

endmodule

@@ sv/csc_checker.sv @@
// ----------------------------------------------------------------------------
// csc_checker
// Port-level checks of the charger stage controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "charger_stage_controller_macros.svh"

module csc_checker
    import csc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic [MODE_W-1:0] charge_mode,
    input logic [PCT_W-1:0]  battery_pct
);

    // a stalled result transaction keeps its payload
    `CSC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(charge_mode) && $stable(battery_pct), "result changed while stalled")

    // percentage never exceeds full scale
    `CSC_ASSERT_NOW(a_pct_range, out_valid, battery_pct <= PCT_W'(PCT_MAX), "battery_pct above 100")

    // mode code stays within the defined stages
    `CSC_ASSERT_NOW(a_mode_range, out_valid, charge_mode <= MODE_W'(ST_FAULT), "charge_mode out of range")

endmodule

bind charger_stage_controller csc_checker u_csc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .charge_mode (charge_mode),
    .battery_pct (battery_pct)
);
